// ===== rtl/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, sizes and keyword tables of the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int TOKEN_BYTES_MAX = 32;
    localparam int ARGS_MAX        = 8;
    localparam int SLOTS           = ARGS_MAX + 1;
    localparam int BANK_SLOTS      = 2 * SLOTS;
    localparam int STORE_DEPTH     = BANK_SLOTS * TOKEN_BYTES_MAX;

    localparam int LEN_W  = $clog2(TOKEN_BYTES_MAX + 1);
    localparam int TC_W   = $clog2(SLOTS + 1);
    localparam int SLOT_W = $clog2(BANK_SLOTS);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int KIND_W = 4;
    localparam int CNT_W  = 4;

    localparam int KEYWORDS = 11;
    localparam int KW_POS   = 8;
    localparam int KW_IDX_W = 3;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic RES_SUMMARY = 1'b0;
    localparam logic RES_READ    = 1'b1;

    localparam logic [KEYWORDS-1:0] MASK_ALL = '1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_TOO_MANY = 2'd3
    } status_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNKNOWN = 4'd0,
        KIND_HELP    = 4'd1,
        KIND_CLEAR   = 4'd2,
        KIND_ECHO    = 4'd3,
        KIND_LS      = 4'd4,
        KIND_CAT     = 4'd5,
        KIND_TOUCH   = 4'd6,
        KIND_WRITE   = 4'd7,
        KIND_APPEND  = 4'd8,
        KIND_RM      = 4'd9,
        KIND_STATUS  = 4'd10,
        KIND_ABOUT   = 4'd11
    } kind_t;

    // Keyword i gives kind i+1; unused positions are padded with zero.
    localparam logic [7:0] KW_TEXT [KEYWORDS][KW_POS] = '{
        '{"h", "e", "l", "p", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "l", "e", "a", "r", 8'h00, 8'h00, 8'h00},
        '{"e", "c", "h", "o", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "a", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "o", "u", "c", "h", 8'h00, 8'h00, 8'h00},
        '{"w", "r", "i", "t", "e", 8'h00, 8'h00, 8'h00},
        '{"a", "p", "p", "e", "n", "d", 8'h00, 8'h00},
        '{"r", "m", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "a", "t", "u", "s", 8'h00, 8'h00},
        '{"a", "b", "o", "u", "t", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KEYWORDS] = '{
        3'd4, 3'd5, 3'd4, 3'd2, 3'd3, 3'd5, 3'd5, 3'd6, 3'd2, 3'd6, 3'd5
    };

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic [3:0] token_select;
        logic [4:0] byte_position;
    } in_item_t;

    typedef struct packed {
        logic             result_type;
        status_t          parse_status;
        kind_t            kind_code;
        logic [CNT_W-1:0] arg_total;
        logic             arity_ok;
        logic [7:0]       read_byte;
    } out_item_t;

    typedef struct packed {
        status_t          status;
        kind_t            kind;
        logic [CNT_W-1:0] args;
        logic             arity;
    } summary_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  pos;
        logic [7:0]        data;
    } byte_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
    } len_wr_t;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
    } commit_t;

endpackage

// ===== rtl/clt_parser.sv =====
// ----------------------------------------------------------------------------
// clt_parser
// Line state: token splitting, keyword match, error latch and line summary.
// ----------------------------------------------------------------------------
module clt_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_take,
    input  logic [7:0]        char_code,
    output clt_pkg::byte_wr_t byte_wr,
    output clt_pkg::len_wr_t  len_wr,
    output clt_pkg::commit_t  commit,
    output clt_pkg::summary_t summary
);
    import clt_pkg::*;

    logic                bank_reg, bank_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LEN_W-1:0]    cur_len_reg, cur_len_next;
    logic [TC_W-1:0]     tc_reg, tc_next;
    logic                inside_reg, inside_next;
    status_t             err_reg, err_next;
    logic [KEYWORDS-1:0] mask_reg, mask_next;
    logic [LEN_W-1:0]    name_len_reg, name_len_next;

    logic                work;
    logic [LEN_W-1:0]    len_eff;
    logic [SLOT_W-1:0]   work_slot;
    logic                is_sep;
    logic                close_at_end;
    logic [TC_W-1:0]     tc_eff;
    logic [LEN_W-1:0]    name_len_eff;
    kind_t               name_kind;
    logic [CNT_W-1:0]    arg_count;
    logic                arity_fit;

    assign work      = ~bank_reg;
    assign len_eff   = inside_reg ? cur_len_reg : '0;
    assign work_slot = work ? SLOT_W'(tc_reg) + SLOT_W'(SLOTS) : SLOT_W'(tc_reg);
    assign is_sep    = (char_code == CH_SPACE) || (char_code == CH_TAB);

    // Close the open token at the end of the line unless an error holds.
    assign close_at_end = (err_reg == ST_OK) && inside_reg;
    assign tc_eff       = close_at_end ? tc_reg + TC_W'(1) : tc_reg;
    assign name_len_eff = (close_at_end && tc_reg == '0) ? cur_len_reg : name_len_reg;
    assign arg_count    = CNT_W'(tc_eff - TC_W'(1));

    // Lowest surviving keyword of the right length wins.
    always_comb
    begin
        name_kind = KIND_UNKNOWN;
        for (int i = KEYWORDS - 1; i >= 0; i--)
        begin
            if (mask_reg[i] && (LEN_W'(KW_LEN[i]) == name_len_eff))
            begin
                name_kind = kind_t'(KIND_W'(i + 1));
            end
        end
    end

    always_comb
    begin
        case (name_kind)
            KIND_HELP, KIND_CLEAR, KIND_LS, KIND_STATUS, KIND_ABOUT:
                arity_fit = (arg_count == '0);
            KIND_CAT, KIND_TOUCH, KIND_RM:
                arity_fit = (arg_count == CNT_W'(1));
            KIND_WRITE, KIND_APPEND:
                arity_fit = (arg_count >= CNT_W'(2)) && (arg_count <= CNT_W'(ARGS_MAX));
            KIND_ECHO:
                arity_fit = (arg_count <= CNT_W'(ARGS_MAX));
            default:
                arity_fit = 1'b0;
        endcase
    end

    always_comb
    begin
        bank_next     = bank_reg;
        count_next    = count_reg;
        cur_len_next  = cur_len_reg;
        tc_next       = tc_reg;
        inside_next   = inside_reg;
        err_next      = err_reg;
        mask_next     = mask_reg;
        name_len_next = name_len_reg;
        byte_wr       = '0;
        len_wr        = '0;
        summary       = '{status: ST_OK, kind: KIND_UNKNOWN, args: '0, arity: 1'b0};

        if (char_take)
        begin
            if (char_code == CH_END)
            begin
                if (close_at_end)
                begin
                    len_wr.en   = 1'b1;
                    len_wr.slot = work_slot;
                    len_wr.len  = cur_len_reg;
                    if (tc_reg == '0)
                    begin
                        name_len_next = cur_len_reg;
                    end
                end
                if (err_reg != ST_OK)
                begin
                    summary.status = err_reg;
                end
                else if (tc_eff == '0)
                begin
                    summary.status = ST_EMPTY;
                end
                else
                begin
                    summary.kind  = name_kind;
                    summary.args  = arg_count;
                    summary.arity = arity_fit;
                    bank_next     = work;
                    count_next    = arg_count;
                end
                // Restart the line.
                cur_len_next = '0;
                tc_next      = '0;
                inside_next  = 1'b0;
                err_next     = ST_OK;
                mask_next    = MASK_ALL;
            end
            else if (err_reg == ST_OK)
            begin
                if (is_sep)
                begin
                    if (inside_reg)
                    begin
                        len_wr.en   = 1'b1;
                        len_wr.slot = work_slot;
                        len_wr.len  = cur_len_reg;
                        if (tc_reg == '0)
                        begin
                            name_len_next = cur_len_reg;
                        end
                        tc_next     = tc_reg + TC_W'(1);
                        inside_next = 1'b0;
                    end
                end
                else if (!inside_reg && (tc_reg >= TC_W'(SLOTS)))
                begin
                    err_next = ST_TOO_MANY;
                end
                else if (len_eff >= LEN_W'(TOKEN_BYTES_MAX))
                begin
                    err_next = ST_TOO_LONG;
                end
                else
                begin
                    inside_next  = 1'b1;
                    byte_wr.en   = 1'b1;
                    byte_wr.slot = work_slot;
                    byte_wr.pos  = len_eff;
                    byte_wr.data = char_code;
                    if (tc_reg == '0)
                    begin
                        for (int i = 0; i < KEYWORDS; i++)
                        begin
                            if (!((len_eff < LEN_W'(KW_LEN[i])) &&
                                  (KW_TEXT[i][len_eff[KW_IDX_W-1:0]] == char_code)))
                            begin
                                mask_next[i] = 1'b0;
                            end
                        end
                    end
                    cur_len_next = len_eff + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= 1'b0;
            count_reg   <= '0;
            cur_len_reg <= '0;
            tc_reg      <= '0;
            inside_reg  <= 1'b0;
            err_reg     <= ST_OK;
            mask_reg    <= MASK_ALL;
        end
        else
        begin
            bank_reg    <= bank_next;
            count_reg   <= count_next;
            cur_len_reg <= cur_len_next;
            tc_reg      <= tc_next;
            inside_reg  <= inside_next;
            err_reg     <= err_next;
            mask_reg    <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_len_reg <= name_len_next;
    end

    assign commit.bank  = bank_reg;
    assign commit.count = count_reg;

endmodule

// ===== rtl/clt_token_store.sv =====
// ----------------------------------------------------------------------------
// clt_token_store
// Two-bank token byte memory and token length registers with read gating.
// ----------------------------------------------------------------------------
module clt_token_store (
    input  logic              clk,
    input  logic              rst_n,
    input  clt_pkg::byte_wr_t byte_wr,
    input  clt_pkg::len_wr_t  len_wr,
    input  clt_pkg::commit_t  commit,
    input  logic              read_take,
    input  logic [3:0]        token_select,
    input  logic [4:0]        byte_position,
    output logic [7:0]        read_byte
);
    import clt_pkg::*;

    logic [7:0]       mem [STORE_DEPTH];
    logic [LEN_W-1:0] len_reg [BANK_SLOTS];
    logic [7:0]       q_reg;
    logic             gate_reg;

    logic              sel_ok;
    logic [SLOT_W-1:0] rd_slot;
    logic              pos_ok;
    logic              gate;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;

    assign sel_ok  = (token_select <= commit.count) && (token_select < SLOTS);
    assign rd_slot = !sel_ok ? '0 :
                     commit.bank ? SLOT_W'(token_select) + SLOT_W'(SLOTS) :
                                   SLOT_W'(token_select);
    assign pos_ok  = (byte_position < TOKEN_BYTES_MAX) &&
                     (LEN_W'(byte_position) < len_reg[rd_slot]);
    assign gate    = sel_ok && pos_ok;

    assign raddr = ADDR_W'(rd_slot) * ADDR_W'(TOKEN_BYTES_MAX) + ADDR_W'(byte_position);
    assign waddr = ADDR_W'(byte_wr.slot) * ADDR_W'(TOKEN_BYTES_MAX) + ADDR_W'(byte_wr.pos);

    always_ff @(posedge clk)
    begin
        if (byte_wr.en)
        begin
            mem[waddr] <= byte_wr.data;
        end
        if (read_take && gate)
        begin
            q_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= 1'b0;
            for (int i = 0; i < BANK_SLOTS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            if (read_take)
            begin
                gate_reg <= gate;
            end
            if (len_wr.en)
            begin
                len_reg[len_wr.slot] <= len_wr.len;
            end
        end
    end

    // Drop bytes at or beyond the token length, and bytes of a token that cannot be selected.
    assign read_byte = gate_reg ? q_reg : 8'h00;

endmodule

// ===== rtl/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Character-at-a-time command line tokenizer with a two-bank token store.
// ----------------------------------------------------------------------------
// Takes one request per clock: a line character or a read of a byte of the
// last committed command. Each zero character yields one parse summary and
// each read yields one data result; both pass through the read stage (beside
// the token memory's registered read port) and then the output register;
// other characters yield nothing. Requests are accepted back to back while
// the output register can drain; a stalled result holds one further result in
// the read stage before request_stall rises. The token memory needs no
// clearing pass after reset.
module command_line_tokenizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_stall,
    input  clt_pkg::in_item_t  request,
    output logic               result_valid,
    input  logic               result_stall,
    output clt_pkg::out_item_t result
);
    import clt_pkg::*;

    logic      accept;
    logic      char_take;
    logic      read_take;
    logic      produce;
    logic      move;

    byte_wr_t  byte_wr;
    len_wr_t   len_wr;
    commit_t   commit;
    summary_t  summary;
    logic [7:0] store_byte;

    logic      s1_valid_reg, s1_valid_next;
    out_item_t s1_item_reg, s1_item_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    assign accept    = request_valid && !request_stall;
    assign char_take = accept && (request.req_type == REQ_CHAR);
    assign read_take = accept && (request.req_type == REQ_READ);
    assign produce   = read_take || (char_take && (request.char_code == CH_END));
    assign move      = s1_valid_reg && (!out_valid_reg || !result_stall);

    assign request_stall = s1_valid_reg && out_valid_reg && result_stall;

    clt_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_take (char_take),
        .char_code (request.char_code),
        .byte_wr   (byte_wr),
        .len_wr    (len_wr),
        .commit    (commit),
        .summary   (summary)
    );

    clt_token_store u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_wr       (byte_wr),
        .len_wr        (len_wr),
        .commit        (commit),
        .read_take     (read_take),
        .token_select  (request.token_select),
        .byte_position (request.byte_position),
        .read_byte     (store_byte)
    );

    always_comb
    begin
        s1_item_next = s1_item_reg;
        if (produce)
        begin
            if (read_take)
            begin
                s1_item_next = '{result_type: RES_READ, parse_status: ST_OK,
                                 kind_code: KIND_UNKNOWN, arg_total: '0,
                                 arity_ok: 1'b0, read_byte: 8'h00};
            end
            else
            begin
                s1_item_next = '{result_type: RES_SUMMARY, parse_status: summary.status,
                                 kind_code: summary.kind, arg_total: summary.args,
                                 arity_ok: summary.arity, read_byte: 8'h00};
            end
        end

        if (produce)
        begin
            s1_valid_next = 1'b1;
        end
        else if (move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        out_item_next = out_item_reg;
        if (move)
        begin
            out_item_next = s1_item_reg;
            if (s1_item_reg.result_type == RES_READ)
            begin
                out_item_next.read_byte = store_byte;
            end
            out_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= s1_item_next;
        out_item_reg <= out_item_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

`ifndef SYNTHESIS
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        request_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("request stalled without a held result");

    a_read_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        read_take |=> (s1_valid_reg && s1_item_reg.result_type == RES_READ))
        else $error("read request did not reach the read stage");

    a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (char_take && request.char_code != CH_END && !s1_valid_reg) |=> !s1_valid_reg)
        else $error("line character produced a result");

    a_read_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_type == RES_READ) |->
        (result.parse_status == ST_OK && result.kind_code == KIND_UNKNOWN &&
         result.arg_total == '0 && !result.arity_ok))
        else $error("read result carries summary fields");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_type == RES_SUMMARY &&
         result.parse_status != ST_OK) |->
        (result.kind_code == KIND_UNKNOWN && result.arg_total == '0 &&
         !result.arity_ok && result.read_byte == 8'h00))
        else $error("failed line summary carries command fields");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the command line tokenizer.
// ----------------------------------------------------------------------------
// Feeds command lines and token store reads through the request channel and
// keeps its own model of the tokenizer: keyword matching, argument counting,
// error latching and the two-bank commit. Every accepted request updates that
// model, and the summaries and read bytes it produces are matched in order
// against the result channel. Both sides insert random idle gaps. Once, the
// result side holds off long enough to back the block up into its request
// side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clt_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 640;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      request_valid = 1'b0;
    logic      request_stall;
    in_item_t  request = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    command_line_tokenizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request       (request),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Tokenizer state as the block should hold it.
    string      keyword_names [KEYWORDS] = '{"help", "clear", "echo", "ls", "cat", "touch",
                                             "write", "append", "rm", "status", "about"};
    logic [7:0] token_store [2][SLOTS][TOKEN_BYTES_MAX] = '{default: 8'h00};
    int         token_len [2][SLOTS] = '{default: 0};
    bit         commit_bank = 1'b0;
    int         open_length = 0;
    int         tokens_in_line = 0;
    bit         in_token = 1'b0;
    status_t    line_error = ST_OK;
    logic [KEYWORDS-1:0] kw_alive = MASK_ALL;
    int         last_args = 0;

    in_item_t   request_backlog [$];
    out_item_t  line_and_read_results [$];

    int  requests_accepted = 0;
    int  reads_predicted = 0;
    int  status_seen [4] = '{default: 0};
    int  mismatches = 0;
    int  pressure_at = 32'h7fff_ffff;
    bit  pressure_done = 1'b0;
    bit  request_taken = 1'b0;
    int  send_gap = 0;
    int  send_calm = 0;
    int  recv_gap = 0;
    int  recv_calm = 0;
    int  hold_cycles = 0;
    int  idle_cycles = 0;

    function automatic bit arity_suits(kind_t k, int n);
        case (k)
            KIND_HELP, KIND_CLEAR, KIND_LS, KIND_STATUS, KIND_ABOUT: return n == 0;
            KIND_CAT, KIND_TOUCH, KIND_RM:                          return n == 1;
            KIND_WRITE, KIND_APPEND: return n >= 2 && n <= ARGS_MAX;
            KIND_ECHO:               return n <= ARGS_MAX;
            default:                 return 1'b0;
        endcase
    endfunction

    task automatic finish_token();
        token_len[!commit_bank][tokens_in_line] = open_length;
        tokens_in_line++;
        in_token = 1'b0;
    endtask

    task automatic take_character(input logic [7:0] c);
        bit wb;
        wb = !commit_bank;
        if (line_error != ST_OK)
            return;
        if (c == CH_SPACE || c == CH_TAB)
        begin
            if (in_token)
                finish_token();
            return;
        end
        if (!in_token)
        begin
            if (tokens_in_line >= SLOTS)
            begin
                line_error = ST_TOO_MANY;
                return;
            end
            in_token = 1'b1;
            open_length = 0;
        end
        if (open_length >= TOKEN_BYTES_MAX)
        begin
            line_error = ST_TOO_LONG;
            return;
        end
        token_store[wb][tokens_in_line][open_length] = c;
        if (tokens_in_line == 0)
        begin
            for (int i = 0; i < KEYWORDS; i++)
                if (open_length >= keyword_names[i].len() || keyword_names[i][open_length] != c)
                    kw_alive[i] = 1'b0;
        end
        open_length++;
    endtask

    task automatic tokenize_step(input in_item_t item);
        out_item_t res;
        kind_t     name_kind;
        bit        wb;
        res = '0;
        if (item.req_type == REQ_READ)
        begin
            res.result_type = RES_READ;
            if (item.token_select <= last_args && item.token_select < SLOTS)
                if (item.byte_position < token_len[commit_bank][item.token_select])
                    res.read_byte =
                        token_store[commit_bank][item.token_select][item.byte_position];
            reads_predicted++;
            line_and_read_results.push_back(res);
        end
        else if (item.char_code != CH_END)
        begin
            take_character(item.char_code);
        end
        else
        begin
            if (line_error == ST_OK && in_token)
                finish_token();
            wb = !commit_bank;
            res.result_type = RES_SUMMARY;
            if (line_error != ST_OK)
                res.parse_status = line_error;
            else if (tokens_in_line == 0)
                res.parse_status = ST_EMPTY;
            else
            begin
                name_kind = KIND_UNKNOWN;
                for (int i = KEYWORDS - 1; i >= 0; i--)
                    if (kw_alive[i] && keyword_names[i].len() == token_len[wb][0])
                        name_kind = kind_t'(4'(i + 1));
                res.parse_status = ST_OK;
                res.kind_code = name_kind;
                res.arg_total = 4'(tokens_in_line - 1);
                res.arity_ok = arity_suits(name_kind, tokens_in_line - 1);
                commit_bank = wb;
                last_args = tokens_in_line - 1;
            end
            status_seen[int'(res.parse_status)]++;
            open_length = 0;
            tokens_in_line = 0;
            in_token = 1'b0;
            line_error = ST_OK;
            kw_alive = MASK_ALL;
            line_and_read_results.push_back(res);
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] random_token_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_TAB);
        return c;
    endfunction

    function automatic int word_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 5);
        if (r < 97)
            return $urandom_range(6, TOKEN_BYTES_MAX - 1);
        return TOKEN_BYTES_MAX;
    endfunction

    // Stimulus builders: fill don't-care fields with noise.
    task automatic queue_char(input logic [7:0] c);
        in_item_t item;
        item.req_type = REQ_CHAR;
        item.char_code = c;
        item.token_select = 4'($urandom_range(0, 15));
        item.byte_position = 5'($urandom_range(0, 31));
        request_backlog.push_back(item);
    endtask

    task automatic queue_read(input int sel, input int pos);
        in_item_t item;
        item.req_type = REQ_READ;
        item.char_code = 8'($urandom_range(0, 255));
        item.token_select = 4'(sel);
        item.byte_position = 5'(pos);
        request_backlog.push_back(item);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i]);
    endtask

    task automatic queue_command(input string s);
        queue_text(s);
        queue_char(CH_END);
    endtask

    task automatic queue_word(input int len);
        repeat (len)
            queue_char(random_token_char());
    endtask

    task automatic queue_separator();
        repeat ($urandom_range(1, 3))
            queue_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic queue_random_line();
        int r;
        int k;
        int nargs;
        in_item_t item;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            // well-formed line, mostly keywords, some near misses
            if ($urandom_range(0, 2) == 0)
                queue_separator();
            k = $urandom_range(0, KEYWORDS + 2);
            if (k < KEYWORDS)
                queue_text(keyword_names[k]);
            else if (k == KEYWORDS)
            begin
                k = $urandom_range(0, KEYWORDS - 1);
                queue_text(keyword_names[k].substr(0, keyword_names[k].len() - 2));
            end
            else if (k == KEYWORDS + 1)
            begin
                queue_text(keyword_names[$urandom_range(0, KEYWORDS - 1)]);
                queue_char(random_token_char());
            end
            else
                queue_word(word_length());
            nargs = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ARGS_MAX)
                                                : $urandom_range(0, 2);
            repeat (nargs)
            begin
                queue_separator();
                queue_word(word_length());
            end
            if ($urandom_range(0, 2) == 0)
                queue_separator();
            queue_char(CH_END);
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_read($urandom_range(0, 15), $urandom_range(0, 31));
                else
                    queue_read($urandom_range(0, nargs + 1), $urandom_range(0, 5));
            end
        end
        else if (r < 80)
        begin
            // raw noise in every field
            repeat ($urandom_range(3, 12))
            begin
                item.req_type = 1'($urandom_range(0, 1));
                item.char_code = 8'($urandom_range(0, 255));
                item.token_select = 4'($urandom_range(0, 15));
                item.byte_position = 5'($urandom_range(0, 31));
                request_backlog.push_back(item);
            end
        end
        else if (r < 86)
        begin
            queue_text(keyword_names[$urandom_range(0, KEYWORDS - 1)]);
            queue_separator();
            queue_word($urandom_range(TOKEN_BYTES_MAX + 1, TOKEN_BYTES_MAX + 6));
            queue_separator();
            queue_word($urandom_range(1, 3));
            queue_char(CH_END);
            queue_read(0, $urandom_range(0, 5));
        end
        else if (r < 93)
        begin
            queue_text("echo");
            repeat ($urandom_range(ARGS_MAX + 1, ARGS_MAX + 3))
            begin
                queue_separator();
                queue_word($urandom_range(1, 3));
            end
            queue_char(CH_END);
            queue_read($urandom_range(0, ARGS_MAX), 0);
        end
        else
        begin
            if ($urandom_range(0, 1))
                queue_separator();
            queue_char(CH_END);
        end
    endtask

    always @(negedge clk)
    begin : request_driver
        if (rst_n && (!request_valid || request_taken))
        begin
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 99) == 0)
                send_calm = 40;
            if (send_gap > 0)
            begin
                send_gap--;
                request_valid <= 1'b0;
            end
            else if (request_backlog.size() != 0)
            begin
                request <= request_backlog.pop_front();
                request_valid <= 1'b1;
                send_gap = (send_calm > 0) ? 0 : idle_length();
            end
            else
                request_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : result_receiver
        if (rst_n)
        begin
            if (!pressure_done && requests_accepted >= pressure_at)
            begin
                pressure_done = 1'b1;
                hold_cycles = 100;
            end
            if (recv_calm > 0)
                recv_calm--;
            else if ($urandom_range(0, 99) == 0)
                recv_calm = 40;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                recv_gap = (recv_calm > 0) ? 0 : idle_length();
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        out_item_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (line_and_read_results.size() == 0)
                begin
                    $error("result with nothing outstanding: %h", result);
                    mismatches++;
                end
                else
                begin
                    want = line_and_read_results.pop_front();
                    check_field("result_type", 8'(want.result_type),
                                8'(result.result_type));
                    check_field("parse_status", 8'(want.parse_status),
                                8'(result.parse_status));
                    check_field("kind_code", 8'(want.kind_code), 8'(result.kind_code));
                    check_field("arg_total", 8'(want.arg_total), 8'(result.arg_total));
                    check_field("arity_ok", 8'(want.arity_ok), 8'(result.arity_ok));
                    check_field("read_byte", want.read_byte, result.read_byte);
                end
            end
            if (request_valid && !request_stall)
            begin
                tokenize_step(request);
                requests_accepted++;
            end
            request_taken <= request_valid && !request_stall;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((request_valid && !request_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int directed_count;

        // reads before anything is committed see empty tokens
        queue_read(0, 0);
        queue_read(ARGS_MAX, 31);
        foreach (keyword_names[i])
        begin
            case (kind_t'(4'(i + 1)))
                KIND_CAT, KIND_TOUCH, KIND_RM: queue_command({keyword_names[i], " f"});
                KIND_WRITE, KIND_APPEND:       queue_command({keyword_names[i], " f\td"});
                KIND_ECHO:                     queue_command(" echo\tone  two ");
                default:                       queue_command(keyword_names[i]);
            endcase
        end
        queue_read(0, 0);
        queue_read(2, 2);
        queue_command("hel");
        queue_command("helpx");
        queue_command("ls x");
        queue_command("write f");
        queue_command("");
        queue_command(" \t ");
        queue_command("echo 1 2 3 4 5 6 7 8");
        queue_read(ARGS_MAX, 0);
        queue_read(ARGS_MAX + 1, 0);
        queue_read(15, 31);
        // one argument too many, then more text that must be dropped
        queue_command("echo 1 2 3 4 5 6 7 8 9 zz");
        queue_read(ARGS_MAX, 0);
        // name of exactly full length with the extreme byte values
        queue_char(8'hff);
        queue_char(8'h01);
        queue_word(TOKEN_BYTES_MAX - 2);
        queue_char(CH_END);
        queue_read(0, 0);
        queue_read(0, 1);
        queue_read(0, TOKEN_BYTES_MAX - 1);
        // one byte too long: previous command must stay readable
        queue_text("cat ");
        queue_word(TOKEN_BYTES_MAX + 1);
        queue_text(" more");
        queue_char(CH_END);
        queue_read(0, 0);
        queue_read(0, TOKEN_BYTES_MAX - 1);

        // a run of reads while the result side holds off
        pressure_at = request_backlog.size();
        repeat (12)
            queue_read($urandom_range(0, 1), $urandom_range(0, 7));

        directed_count = request_backlog.size();
        while (request_backlog.size() < directed_count + RANDOM_ITEMS)
            queue_random_line();
        queue_command("help");

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || request_valid)
            @(posedge clk);
        while (line_and_read_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d requests: %0d lines (ok %0d, empty %0d, too long %0d, too many %0d)",
                 requests_accepted, status_seen[0] + status_seen[1] + status_seen[2]
                 + status_seen[3], status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        $display("%0d token store reads, %0d field mismatches", reads_predicted, mismatches);
        if (mismatches == 0 && line_and_read_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/clt_pkg.sv
rtl/clt_parser.sv
rtl/clt_token_store.sv
rtl/command_line_tokenizer.sv
bench/testbench.sv
